FILE: rtl/core/rsrcb_pkg.sv
// Package for the run-length sprite row blitter core.
// Holds field widths, register indexes, reset values and the shared structs.
// No dependencies.
package rsrcb_pkg;

   // Widths of the transaction fields and configuration registers
   localparam int AddrBitsDefault = 20;
   localparam int FieldAddrBits   = 20;
   localparam int ByteBits        = 8;
   localparam int PitchBits       = 12;
   localparam int WidthBits       = 8;
   localparam int RunBits         = 7;
   localparam int BackBits        = 13;
   localparam int CsrIndexBits    = 2;
   localparam int CsrDataBits     = 20;

   // Register indexes on the configuration port
   localparam logic [CsrIndexBits-1:0] CSR_LINE_PITCH   = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_SPRITE_WIDTH = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_CLIP_LOW     = 2'd2;
   localparam logic [CsrIndexBits-1:0] CSR_CLIP_HIGH    = 2'd3;

   // Reset values of the configuration registers
   localparam logic [PitchBits-1:0]     LinePitchReset   = 12'd768;
   localparam logic [WidthBits-1:0]     SpriteWidthReset = 8'd22;
   localparam logic [FieldAddrBits-1:0] ClipLowReset     = 20'd160512;
   localparam logic [FieldAddrBits-1:0] ClipHighReset    = 20'd360192;

   // A header byte with this bit set is a transparent skip
   localparam int SkipFlagBit = 7;
   // A skip of byte b covers SkipBase - b pixels
   localparam logic [ByteBits:0] SkipBase = 9'd256;

   typedef struct packed {
      logic [PitchBits-1:0]     line_pitch;
      logic [WidthBits-1:0]     sprite_width;
      logic [FieldAddrBits-1:0] clip_low;
      logic [FieldAddrBits-1:0] clip_high;
   } cfg_type;

   typedef struct packed {
      logic [ByteBits-1:0]      data_byte;
      logic                     frame_start;
      logic [FieldAddrBits-1:0] start_addr;
   } req_type;

endpackage

FILE: rtl/core/rsrcb_step.sv
// Next-state and result logic for one byte of a run-length sprite frame.
// Purely combinational; depends on rsrcb_pkg.
module rsrcb_step #(
   parameter int ADDR_BITS = rsrcb_pkg::AddrBitsDefault
) (
   input  rsrcb_pkg::cfg_type                       cfg,
   input  rsrcb_pkg::req_type                       req,
   input  logic [ADDR_BITS-1:0]                     cur_addr,
   input  logic [rsrcb_pkg::WidthBits-1:0]          cols_left,
   input  logic [rsrcb_pkg::RunBits-1:0]            run_left,
   input  logic                                     run_visible,
   output logic [ADDR_BITS-1:0]                     cur_addr_next,
   output logic [rsrcb_pkg::WidthBits-1:0]          cols_left_next,
   output logic [rsrcb_pkg::RunBits-1:0]            run_left_next,
   output logic                                     run_visible_next,
   output logic                                     produce,
   output logic [rsrcb_pkg::FieldAddrBits-1:0]      write_addr
);
   import rsrcb_pkg::*;

   localparam int CmpBits  = (ADDR_BITS > FieldAddrBits) ? ADDR_BITS : FieldAddrBits;
   localparam int BackCmp  = (ADDR_BITS > BackBits) ? ADDR_BITS : BackBits;

   logic [ADDR_BITS-1:0] addr_base;
   logic [WidthBits-1:0] cols_base;
   logic [RunBits-1:0]   run_base;
   logic                 vis_base;
   logic [ADDR_BITS-1:0] addr_mid;
   logic [WidthBits-1:0] cols_mid;
   logic                 row_check;
   logic [WidthBits-1:0] lit_len;
   logic [WidthBits-1:0] skip_len;
   logic [BackBits-1:0]  back;
   logic [BackCmp-1:0]   addr_wide;
   logic [BackCmp-1:0]   back_wide;
   logic                 in_window;

   // Row step back and run lengths
   assign back      = BackBits'(cfg.line_pitch) + BackBits'(cfg.sprite_width);
   assign lit_len   = {1'b0, req.data_byte[RunBits-1:0]};
   assign skip_len  = WidthBits'(SkipBase - {1'b0, req.data_byte});
   assign back_wide = BackCmp'(back);

   always_comb begin
      // A frame start reloads the address and drops any pending run
      addr_base = cur_addr;
      cols_base = cols_left;
      run_base  = run_left;
      vis_base  = run_visible;
      if (req.frame_start) begin
         addr_base = ADDR_BITS'(req.start_addr);
         cols_base = cfg.sprite_width;
         run_base  = '0;
         vis_base  = 1'b0;
      end

      // A run is drawn only when it starts inside the clip window
      in_window = (CmpBits'(addr_base) >= CmpBits'(cfg.clip_low)) &&
                  (CmpBits'(addr_base) <= CmpBits'(cfg.clip_high));

      addr_mid         = addr_base;
      cols_mid         = cols_base;
      run_left_next    = run_base;
      run_visible_next = vis_base;
      row_check        = 1'b0;
      produce          = 1'b0;

      if (!req.frame_start && (run_left != '0)) begin
         // Literal pixel of an open run
         produce       = run_visible;
         addr_mid      = addr_base + ADDR_BITS'(1'b1);
         run_left_next = run_base - RunBits'(1'b1);
         row_check     = (run_left_next == '0);
      end else if (!req.data_byte[SkipFlagBit]) begin
         // Literal run header; a zero-length run only checks for row end
         if (lit_len == '0) begin
            row_check = 1'b1;
         end else begin
            cols_mid         = (cols_base >= lit_len) ? (cols_base - lit_len) : '0;
            run_visible_next = in_window;
            run_left_next    = req.data_byte[RunBits-1:0];
         end
      end else begin
         // Transparent skip
         addr_mid  = addr_base + ADDR_BITS'(skip_len);
         cols_mid  = (cols_base >= skip_len) ? (cols_base - skip_len) : '0;
         row_check = 1'b1;
      end

      // Row end: step up one row, saturating at address zero
      addr_wide      = BackCmp'(addr_mid);
      cur_addr_next  = addr_mid;
      cols_left_next = cols_mid;
      if (row_check && (cols_mid == '0)) begin
         cur_addr_next  = (addr_wide >= back_wide) ?
                          ADDR_BITS'(addr_wide - back_wide) : '0;
         cols_left_next = cfg.sprite_width;
      end
   end

   assign write_addr = FieldAddrBits'(cur_addr);

endmodule

FILE: rtl/core/rle_sprite_row_clip_blitter_core.sv
// Top level of the run-length sprite row blitter with vertical clip.
// Depends on rsrcb_pkg and rsrcb_step.

// Decodes a transparent run-length sprite frame, one encoded byte per
// transaction, into frame-buffer pixel writes. The block takes one byte every
// clock cycle while the output is free or being taken; each byte passes the
// input register and its write the output register. Throughput is set by the
// step logic that updates the address, column and run state. Each byte is
// held in an input register, the step logic works out the new state and any
// pixel write, and the write sits in an output register; the input side keeps
// moving while the output is free or being taken. Configuration writes are
// always ready and must be issued while no bytes are in flight.
module rle_sprite_row_clip_blitter_core #(
   parameter int ADDR_BITS = rsrcb_pkg::AddrBitsDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Encoded byte input
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [rsrcb_pkg::ByteBits-1:0]          req_data_byte,
   input  logic                                    req_frame_start,
   input  logic [rsrcb_pkg::FieldAddrBits-1:0]     req_start_addr,
   // Pixel write output
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [rsrcb_pkg::FieldAddrBits-1:0]     rsp_write_addr,
   output logic [rsrcb_pkg::ByteBits-1:0]          rsp_pixel_value,
   // Configuration writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rsrcb_pkg::CsrIndexBits-1:0]      csr_index,
   input  logic [rsrcb_pkg::CsrDataBits-1:0]       csr_data
);
   import rsrcb_pkg::*;

   cfg_type                  cfg_ff;
   req_type                  req_ff;
   logic                     req_valid_ff;
   logic [ADDR_BITS-1:0]     cur_addr_ff;
   logic [WidthBits-1:0]     cols_left_ff;
   logic [RunBits-1:0]       run_left_ff;
   logic                     run_visible_ff;
   logic                     rsp_valid_ff;
   logic [FieldAddrBits-1:0] rsp_write_addr_ff;
   logic [ByteBits-1:0]      rsp_pixel_value_ff;

   logic [ADDR_BITS-1:0]     cur_addr_in;
   logic [WidthBits-1:0]     cols_left_in;
   logic [RunBits-1:0]       run_left_in;
   logic                     run_visible_in;
   logic                     produce;
   logic [FieldAddrBits-1:0] step_write_addr;
   logic                     out_free;
   logic                     step_go;
   logic                     req_take;

   // Handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_go   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_pitch   <= LinePitchReset;
         cfg_ff.sprite_width <= SpriteWidthReset;
         cfg_ff.clip_low     <= ClipLowReset;
         cfg_ff.clip_high    <= ClipHighReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LINE_PITCH:   cfg_ff.line_pitch   <= csr_data[PitchBits-1:0];
            CSR_SPRITE_WIDTH: cfg_ff.sprite_width <= csr_data[WidthBits-1:0];
            CSR_CLIP_LOW:     cfg_ff.clip_low     <= csr_data[FieldAddrBits-1:0];
            CSR_CLIP_HIGH:    cfg_ff.clip_high    <= csr_data[FieldAddrBits-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.data_byte   <= req_data_byte;
         req_ff.frame_start <= req_frame_start;
         req_ff.start_addr  <= req_start_addr;
      end
   end

   // Step logic for the registered byte
   rsrcb_step #(
      .ADDR_BITS (ADDR_BITS)
   ) u_step (
      .cfg              (cfg_ff),
      .req              (req_ff),
      .cur_addr         (cur_addr_ff),
      .cols_left        (cols_left_ff),
      .run_left         (run_left_ff),
      .run_visible      (run_visible_ff),
      .cur_addr_next    (cur_addr_in),
      .cols_left_next   (cols_left_in),
      .run_left_next    (run_left_in),
      .run_visible_next (run_visible_in),
      .produce          (produce),
      .write_addr       (step_write_addr)
   );

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_addr_ff    <= '0;
         cols_left_ff   <= '0;
         run_left_ff    <= '0;
         run_visible_ff <= 1'b0;
      end else if (step_go) begin
         cur_addr_ff    <= cur_addr_in;
         cols_left_ff   <= cols_left_in;
         run_left_ff    <= run_left_in;
         run_visible_ff <= run_visible_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step_go && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go && produce) begin
         rsp_write_addr_ff  <= step_write_addr;
         rsp_pixel_value_ff <= req_ff.data_byte;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_addr  = rsp_write_addr_ff;
   assign rsp_pixel_value = rsp_pixel_value_ff;

`ifndef SYNTHESIS
   // A pixel write appears only after a byte has left the input register.
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step_go))
      else $error("pixel write appeared without a decoded byte");

   // A pixel of a visible run always gives a write.
   a_visible_pixel: assert property (@(posedge clock) disable iff (reset)
      (step_go && !req_ff.frame_start && (run_left_ff != '0) && run_visible_ff)
      |=> rsp_valid)
      else $error("visible literal pixel gave no write");

   // A nonzero literal header opens a run.
   a_run_opens: assert property (@(posedge clock) disable iff (reset)
      (step_go && (req_ff.frame_start || (run_left_ff == '0)) &&
       !req_ff.data_byte[SkipFlagBit] && (req_ff.data_byte[RunBits-1:0] != '0))
      |=> (run_left_ff != '0))
      else $error("literal header did not open a run");
`endif

endmodule
